>>> src/dhrs_pkg.sv
// Shared types and constants for the disk head request scheduler.
`default_nettype none

package dhrs_pkg;

  localparam int unsigned CYL_W    = 16;
  localparam int unsigned TRAVEL_W = 22;
  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = {TRAVEL_W{1'b1}};

  // Command codes.
  localparam logic [1:0] OP_SET_HEAD = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;

  // Policy codes.
  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_SCAN  = 2'd1;
  localparam logic [1:0] POL_CSCAN = 2'd2;

  // Configuration register indexes.
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_END_CYL = 1'b1;

  // Which requests a sweep may pick, relative to the head.
  typedef enum logic [1:0] {
    CLS_LE = 2'd0,
    CLS_GT = 2'd1,
    CLS_GE = 2'd2,
    CLS_LT = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic ascend;
    logic have_last;
  } srch_ctl_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [CYL_W-1:0] cylinder;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]    position;
    logic [TRAVEL_W-1:0] total_travel;
    logic                is_last;
    logic                overflow;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/disk_head_request_scheduler.sv
// Top level of the disk head request scheduler.
// A run emits the head and then one result per stored request, one result per
// strobe, with the total travel on the last one. FCFS reads the stored requests
// in a single pass. SCAN and C-SCAN run a statistics pass, three travel steps
// and, with n stored requests (n of one or more), n + 2 search passes, because
// each path item takes a full pass over the request RAM through its single read
// port and the one shared compare unit. A run with no requests goes straight to
// its last result. The last result strobes in the same cycle that busy drops.
// Results cannot be held off: every strobe is a transfer.
`default_nettype none

module disk_head_request_scheduler #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire dhrs_pkg::in_item_t            in_data,
  output logic                               out_valid,
  output dhrs_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [dhrs_pkg::CYL_W-1:0]    cfg_data
);

  localparam int unsigned AW    = $clog2(MAX_REQUESTS);
  localparam int unsigned CW    = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned CYW   = dhrs_pkg::CYL_W;
  localparam int unsigned KEY_W = CYW + AW;
  localparam int unsigned TW    = dhrs_pkg::TRAVEL_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STAT, ST_TRAV, ST_SRCH, ST_PICK, ST_FCFS, ST_LAST
  } state_t;

  state_t state_r;

  // Configuration and stored state.
  logic [1:0]     policy_r;
  logic [CYW-1:0] end_cyl_r;
  logic [CYW-1:0] head_r;
  logic [CW-1:0]  count_r;
  logic           drop_r;

  // RAM read pass.
  logic [AW-1:0]  issue_r;
  logic           iss_r;
  logic           rdv_r;
  logic [AW-1:0]  ridx_r;
  logic           rlast_r;
  logic           issue_last;
  logic           pass_done;
  logic [CYW-1:0] rdata;
  logic           ram_we;

  // Statistics of the stored requests.
  logic [CYW-1:0] smin_r, smax_r, max_lo_r, min_hi_r;
  logic           any_lo_r, any_hi_r;

  // Sweep control.
  logic [1:0]       tstep_r;
  logic             asc0_r;
  logic             phase_r;
  logic             have_last_r;
  logic [KEY_W-1:0] last_key_r;
  logic [KEY_W-1:0] best_key_r;
  logic             best_vld_r;
  logic [KEY_W-1:0] cand_key;
  logic             take;
  dhrs_pkg::srch_ctl_t ctl;

  // Pending path item and travel accumulator.
  logic           pend_vld_r;
  logic [CYW-1:0] pend_pos_r;
  logic [TW-1:0]  travel_r;

  logic           is_scan, is_cscan;
  logic [CYW-1:0] top_a, top_c, top_minus_h;
  logic           asc0_c;
  logic [CYW-1:0] term_c, absdiff, add_in;
  logic [TW:0]    sum;
  logic [TW-1:0]  travel_sat;

  assign is_scan  = (policy_r == dhrs_pkg::POL_SCAN);
  assign is_cscan = (policy_r == dhrs_pkg::POL_CSCAN);
  assign busy     = (state_r != ST_IDLE);
  assign ram_we   = (state_r == ST_IDLE) && start &&
                    (in_data.op == dhrs_pkg::OP_ADD) &&
                    (count_r < CW'(MAX_REQUESTS));

  dhrs_ram #(.WIDTH(CYW), .DEPTH(MAX_REQUESTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.cylinder),
    .raddr (issue_r),
    .rdata (rdata)
  );

  assign issue_last = (CW'(issue_r) == (count_r - CW'(1)));
  assign pass_done  = rdv_r && rlast_r;

  // Sweep end and first sweep direction.
  assign top_a       = (end_cyl_r > head_r) ? end_cyl_r : head_r;
  assign top_c       = (smax_r > top_a) ? smax_r : top_a;
  assign top_minus_h = top_c - head_r;
  assign asc0_c      = is_cscan ? (head_r >= top_minus_h) : !(head_r <= top_minus_h);

  // Travel terms of the sweeping policies, one per step.
  always_comb begin
    case (tstep_r)
      2'd0: term_c = asc0_c ? top_minus_h : head_r;
      2'd1: begin
        if (is_cscan) begin
          term_c = (asc0_c ? any_lo_r : any_hi_r) ? top_c : '0;
        end else if (asc0_c) begin
          term_c = any_lo_r ? (top_c - smin_r) : '0;
        end else begin
          term_c = any_hi_r ? smax_r : '0;
        end
      end
      2'd2: begin
        if (!is_cscan) begin
          term_c = '0;
        end else if (asc0_c) begin
          term_c = any_lo_r ? max_lo_r : '0;
        end else begin
          term_c = any_hi_r ? (top_c - min_hi_r) : '0;
        end
      end
      default: term_c = '0;
    endcase
  end

  // Shared saturating travel adder.
  assign absdiff    = (rdata > pend_pos_r) ? (rdata - pend_pos_r) : (pend_pos_r - rdata);
  assign add_in     = (state_r == ST_FCFS) ? absdiff : term_c;
  assign sum        = {1'b0, travel_r} + (TW + 1)'(add_in);
  assign travel_sat = sum[TW] ? dhrs_pkg::TRAVEL_MAX : sum[TW-1:0];

  // Search control for the current sweep.
  always_comb begin
    ctl.have_last = have_last_r;
    if (!phase_r) begin
      ctl.cls    = asc0_r ? dhrs_pkg::CLS_GE : dhrs_pkg::CLS_LE;
      ctl.ascend = asc0_r;
    end else begin
      ctl.cls    = asc0_r ? dhrs_pkg::CLS_LT : dhrs_pkg::CLS_GT;
      ctl.ascend = is_scan ? !asc0_r : asc0_r;
    end
  end

  assign cand_key = {rdata, ridx_r};

  dhrs_cmp #(.IDX_W(AW)) u_cmp (
    .ctl      (ctl),
    .head     (head_r),
    .cand_key (cand_key),
    .last_key (last_key_r),
    .best_key (best_key_r),
    .best_vld (best_vld_r),
    .take     (take)
  );

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      policy_r   <= dhrs_pkg::POL_FCFS;
      end_cyl_r  <= CYW'(199);
      head_r     <= '0;
      count_r    <= '0;
      drop_r     <= 1'b0;
      iss_r      <= 1'b0;
      rdv_r      <= 1'b0;
      rlast_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;

      // Read pass over the stored requests.
      if (iss_r) begin
        if (issue_last) begin
          iss_r <= 1'b0;
        end else begin
          issue_r <= issue_r + AW'(1);
        end
      end
      rdv_r   <= iss_r;
      ridx_r  <= issue_r;
      rlast_r <= iss_r && issue_last;

      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          dhrs_pkg::REG_POLICY:  policy_r  <= cfg_data[1:0];
          dhrs_pkg::REG_END_CYL: end_cyl_r <= cfg_data;
          default:               policy_r  <= policy_r;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            case (in_data.op)
              dhrs_pkg::OP_SET_HEAD: head_r <= in_data.cylinder;
              dhrs_pkg::OP_ADD: begin
                if (count_r < CW'(MAX_REQUESTS)) begin
                  count_r <= count_r + CW'(1);
                end else begin
                  drop_r <= 1'b1;
                end
              end
              dhrs_pkg::OP_RUN: begin
                pend_vld_r <= 1'b1;
                pend_pos_r <= head_r;
                travel_r   <= '0;
                smin_r     <= '1;
                smax_r     <= '0;
                any_lo_r   <= 1'b0;
                any_hi_r   <= 1'b0;
                tstep_r    <= '0;
                if (count_r == '0) begin
                  state_r <= ST_LAST;
                end else begin
                  issue_r <= '0;
                  iss_r   <= 1'b1;
                  state_r <= (is_scan || is_cscan) ? ST_STAT : ST_FCFS;
                end
              end
              default: head_r <= head_r;
            endcase
          end
        end

        ST_STAT: begin
          if (rdv_r) begin
            if (rdata < smin_r) smin_r <= rdata;
            if (rdata > smax_r) smax_r <= rdata;
            if ((rdata < head_r) && (!any_lo_r || (rdata > max_lo_r))) begin
              max_lo_r <= rdata;
              any_lo_r <= 1'b1;
            end
            if ((rdata > head_r) && (!any_hi_r || (rdata < min_hi_r))) begin
              min_hi_r <= rdata;
              any_hi_r <= 1'b1;
            end
          end
          if (pass_done) begin
            state_r <= ST_TRAV;
          end
        end

        ST_TRAV: begin
          travel_r <= travel_sat;
          tstep_r  <= tstep_r + 2'd1;
          if (tstep_r == 2'd2) begin
            asc0_r      <= asc0_c;
            phase_r     <= 1'b0;
            have_last_r <= 1'b0;
            best_vld_r  <= 1'b0;
            issue_r     <= '0;
            iss_r       <= 1'b1;
            state_r     <= ST_SRCH;
          end
        end

        ST_SRCH: begin
          if (rdv_r && take) begin
            best_key_r <= cand_key;
            best_vld_r <= 1'b1;
          end
          if (pass_done) begin
            state_r <= ST_PICK;
          end
        end

        ST_PICK: begin
          best_vld_r <= 1'b0;
          if (best_vld_r) begin
            // Transfer the pending item and keep the new one back.
            out_valid             <= pend_vld_r;
            out_data.position     <= pend_pos_r;
            out_data.total_travel <= '0;
            out_data.is_last      <= 1'b0;
            out_data.overflow     <= drop_r;
            pend_pos_r            <= best_key_r[KEY_W-1 -: CYW];
            last_key_r            <= best_key_r;
            have_last_r           <= 1'b1;
            issue_r               <= '0;
            iss_r                 <= 1'b1;
            state_r               <= ST_SRCH;
          end else if (!phase_r) begin
            phase_r     <= 1'b1;
            have_last_r <= 1'b0;
            issue_r     <= '0;
            iss_r       <= 1'b1;
            state_r     <= ST_SRCH;
          end else begin
            state_r <= ST_LAST;
          end
        end

        ST_FCFS: begin
          if (rdv_r) begin
            travel_r              <= travel_sat;
            out_valid             <= pend_vld_r;
            out_data.position     <= pend_pos_r;
            out_data.total_travel <= '0;
            out_data.is_last      <= 1'b0;
            out_data.overflow     <= drop_r;
            pend_pos_r            <= rdata;
          end
          if (pass_done) begin
            state_r <= ST_LAST;
          end
        end

        ST_LAST: begin
          out_valid             <= 1'b1;
          out_data.position     <= pend_pos_r;
          out_data.total_travel <= travel_r;
          out_data.is_last      <= 1'b1;
          out_data.overflow     <= drop_r;
          pend_vld_r            <= 1'b0;
          count_r               <= '0;
          drop_r                <= 1'b0;
          state_r               <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/dhrs_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none

module dhrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/dhrs_cmp.sv
// Compare unit that decides whether a stored request becomes the next sweep candidate.
`default_nettype none

module dhrs_cmp #(
  parameter int unsigned IDX_W = 5
) (
  input  wire dhrs_pkg::srch_ctl_t                 ctl,
  input  wire logic [dhrs_pkg::CYL_W-1:0]          head,
  input  wire logic [dhrs_pkg::CYL_W+IDX_W-1:0]    cand_key,
  input  wire logic [dhrs_pkg::CYL_W+IDX_W-1:0]    last_key,
  input  wire logic [dhrs_pkg::CYL_W+IDX_W-1:0]    best_key,
  input  wire logic                                best_vld,
  output logic                                     take
);

  localparam int unsigned KEY_W = dhrs_pkg::CYL_W + IDX_W;

  logic [dhrs_pkg::CYL_W-1:0] cand_val;
  logic cls_ok;
  logic after_last;
  logic beats_best;

  assign cand_val = cand_key[KEY_W-1 -: dhrs_pkg::CYL_W];

  // Side of the head the current sweep covers.
  always_comb begin
    unique case (ctl.cls)
      dhrs_pkg::CLS_LE: cls_ok = (cand_val <= head);
      dhrs_pkg::CLS_GT: cls_ok = (cand_val > head);
      dhrs_pkg::CLS_GE: cls_ok = (cand_val >= head);
      dhrs_pkg::CLS_LT: cls_ok = (cand_val < head);
      default:          cls_ok = 1'b0;
    endcase
  end

  // The key, value then index, must lie beyond the last one served and
  // nearer than the best one found so far in this pass.
  assign after_last = !ctl.have_last ||
                      (ctl.ascend ? (cand_key > last_key) : (cand_key < last_key));
  assign beats_best = !best_vld ||
                      (ctl.ascend ? (cand_key < best_key) : (cand_key > best_key));
  assign take = cls_ok && after_last && beats_best;

endmodule

`default_nettype wire

>>> src/dhrs_checker.sv
// Port-level checker for the disk head request scheduler, with its bind.
`default_nettype none

module dhrs_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire dhrs_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire dhrs_pkg::out_item_t out_data
);

  // The block comes out of reset ready for a command.
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // Results only come from a run in progress.
  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside a run");

  // Set-head and add-request commands produce no result.
  a_no_result_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.op != dhrs_pkg::OP_RUN)) |=> !out_valid)
    else $error("result from a non-run command");

  // The last transfer of a run is followed by a gap.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_last) |=> !out_valid)
    else $error("result after last item");

  // Travel is reported on the last item only.
  a_travel_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_last) |-> (out_data.total_travel == '0))
    else $error("travel on a non-last item");

endmodule

bind disk_head_request_scheduler dhrs_checker u_dhrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the disk head request scheduler.
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int NREQ = 32;
  localparam int CYW  = dhrs_pkg::CYL_W;

  // Codes outside the defined sets.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  dhrs_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  dhrs_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CYW-1:0]      cfg_data = '0;

  // Shadow copy of the scheduler state.
  logic [CYW-1:0] req_fifo [NREQ];
  int             req_count;
  logic [CYW-1:0] head_pos;
  logic           dropped;
  logic [1:0]     policy;
  logic [CYW-1:0] end_cyl;

  dhrs_pkg::out_item_t path_queue [$];
  int        error_count = 0;
  int        paths_seen = 0;
  int        runs_sent = 0;
  int        items_sent = 0;
  bit        no_idle = 1'b0;

  always #10 clk = ~clk;

  disk_head_request_scheduler #(.MAX_REQUESTS(NREQ)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Random cylinder over the full field.
  function automatic logic [CYW-1:0] rnd_cyl();
    logic [31:0] r;
    r = $urandom;
    return r[CYW-1:0];
  endfunction

  // Random cylinder from zero up to a limit.
  function automatic logic [CYW-1:0] rnd_upto(logic [CYW-1:0] lim);
    logic [31:0] r;
    r = $urandom_range({{(32-CYW){1'b0}}, lim});
    return r[CYW-1:0];
  endfunction

  // Append one path point to the expected path.
  function automatic void push_point(int unsigned pos);
    dhrs_pkg::out_item_t r;
    r = '0;
    r.position = pos[CYW-1:0];
    r.overflow = dropped;
    path_queue.push_back(r);
  endfunction

  // Compute the service path and total travel of a run, then clear the requests.
  function automatic void schedule_run();
    int unsigned s [NREQ];
    int unsigned h, top, travel, prev, max_lo, min_hi, x;
    int n, i, j;
    bit any_lo, any_hi;
    dhrs_pkg::out_item_t last;
    n = req_count;
    h = 32'(head_pos);
    travel = 0;
    any_lo = 0;
    any_hi = 0;
    max_lo = 0;
    min_hi = 0;
    for (i = 0; i < n; i++) s[i] = 32'(req_fifo[i]);
    push_point(h);
    if (policy == dhrs_pkg::POL_SCAN || policy == dhrs_pkg::POL_CSCAN) begin
      for (i = 1; i < n; i++) begin
        x = s[i];
        j = i - 1;
        while (j >= 0 && s[j] > x) begin
          s[j + 1] = s[j];
          j--;
        end
        s[j + 1] = x;
      end
      top = 32'(end_cyl);
      if (h > top) top = h;
      if (n > 0 && s[n - 1] > top) top = s[n - 1];
      for (i = 0; i < n; i++) begin
        if (s[i] < h) begin
          any_lo = 1;
          max_lo = s[i];
        end
        if (s[i] > h && !any_hi) begin
          any_hi = 1;
          min_hi = s[i];
        end
      end
      if (policy == dhrs_pkg::POL_SCAN) begin
        if (h <= top - h) begin
          for (i = n - 1; i >= 0; i--) if (s[i] <= h) push_point(s[i]);
          for (i = 0; i < n; i++) if (s[i] > h) push_point(s[i]);
          travel = h + (any_hi ? s[n - 1] : 32'd0);
        end else begin
          for (i = 0; i < n; i++) if (s[i] >= h) push_point(s[i]);
          for (i = n - 1; i >= 0; i--) if (s[i] < h) push_point(s[i]);
          travel = (top - h) + (any_lo ? top - s[0] : 32'd0);
        end
      end else begin
        if (h >= top - h) begin
          for (i = 0; i < n; i++) if (s[i] >= h) push_point(s[i]);
          for (i = 0; i < n; i++) if (s[i] < h) push_point(s[i]);
          travel = (top - h) + (any_lo ? top + max_lo : 32'd0);
        end else begin
          for (i = n - 1; i >= 0; i--) if (s[i] <= h) push_point(s[i]);
          for (i = n - 1; i >= 0; i--) if (s[i] > h) push_point(s[i]);
          travel = h + (any_hi ? top + (top - min_hi) : 32'd0);
        end
      end
    end else begin
      // First come first serve, also taken for the unused policy code.
      prev = h;
      for (i = 0; i < n; i++) begin
        travel += (s[i] > prev) ? s[i] - prev : prev - s[i];
        prev = s[i];
        push_point(s[i]);
      end
    end
    if (n == 0) travel = 0;
    if (travel > 32'(dhrs_pkg::TRAVEL_MAX)) travel = 32'(dhrs_pkg::TRAVEL_MAX);
    last = path_queue.pop_back();
    last.total_travel = travel[dhrs_pkg::TRAVEL_W-1:0];
    last.is_last = 1'b1;
    path_queue.push_back(last);
    req_count = 0;
    dropped = 1'b0;
  endfunction

  // Update the shadow state for one accepted command.
  function automatic void apply_command(dhrs_pkg::in_item_t it);
    case (it.op)
      dhrs_pkg::OP_SET_HEAD: head_pos = it.cylinder;
      dhrs_pkg::OP_ADD: begin
        if (req_count < NREQ) begin
          req_fifo[req_count] = it.cylinder;
          req_count++;
        end else begin
          dropped = 1'b1;
        end
      end
      dhrs_pkg::OP_RUN: begin
        schedule_run();
        runs_sent++;
      end
      default: ;
    endcase
  endfunction

  // Check every path point against the oldest expectation.
  always @(negedge clk) begin
    dhrs_pkg::out_item_t exp_item;
    if (rst_n && out_valid) begin
      paths_seen++;
      if (path_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        exp_item = path_queue.pop_front();
        if (out_data.position !== exp_item.position) begin
          $display("%0t: position expected %0d actual %0d", $time,
                   exp_item.position, out_data.position);
          error_count++;
        end
        if (out_data.total_travel !== exp_item.total_travel) begin
          $display("%0t: total_travel expected %0d actual %0d", $time,
                   exp_item.total_travel, out_data.total_travel);
          error_count++;
        end
        if (out_data.is_last !== exp_item.is_last) begin
          $display("%0t: is_last expected %0b actual %0b", $time,
                   exp_item.is_last, out_data.is_last);
          error_count++;
        end
        if (out_data.overflow !== exp_item.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   exp_item.overflow, out_data.overflow);
          error_count++;
        end
      end
    end
  end

  // Transfer one command; called and returning at a rising edge.
  task automatic send_cmd(logic [1:0] op, logic [CYW-1:0] cyl);
    dhrs_pkg::in_item_t it;
    it.op = op;
    it.cylinder = cyl;
    while (!no_idle && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (busy);
    @(posedge clk);
    apply_command(it);
    items_sent++;
  endtask

  // Drain all results, let the block settle, then write a register.
  task automatic write_reg(logic idx, logic [CYW-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (path_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dhrs_pkg::REG_POLICY) policy = val[1:0];
    else end_cyl = val;
  endtask

  task automatic set_config(logic [1:0] pol, logic [CYW-1:0] endc);
    write_reg(dhrs_pkg::REG_POLICY, {{(CYW-2){1'b0}}, pol});
    write_reg(dhrs_pkg::REG_END_CYL, endc);
  endtask

  // Fixed scenario: head, a list of requests, then a run.
  task automatic run_list(logic [CYW-1:0] head, logic [CYW-1:0] reqs [$]);
    send_cmd(dhrs_pkg::OP_SET_HEAD, head);
    foreach (reqs[i]) send_cmd(dhrs_pkg::OP_ADD, reqs[i]);
    send_cmd(dhrs_pkg::OP_RUN, rnd_cyl());
  endtask

  // Empty run at reset settings, extremes of the fields, unused op code.
  task automatic test_extremes();
    send_cmd(dhrs_pkg::OP_RUN, 16'hFFFF);
    run_list(16'hFFFF, '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_cmd(OP_UNUSED, 16'h1234);
    run_list(16'd50, '{16'd50, 16'd10});
  endtask

  // Each policy in both sweep directions, with a request at the head.
  task automatic test_policies();
    set_config(dhrs_pkg::POL_SCAN, 16'd199);
    run_list(16'd40, '{16'd90, 16'd40, 16'd5, 16'd180});
    run_list(16'd150, '{16'd90, 16'd150, 16'd5, 16'd180});
    set_config(dhrs_pkg::POL_CSCAN, 16'd199);
    run_list(16'd150, '{16'd90, 16'd150, 16'd5, 16'd180});
    run_list(16'd40, '{16'd90, 16'd40, 16'd5, 16'd180});
    // Requests past the configured end move the top end outward.
    run_list(16'd30, '{16'd500, 16'd2});
    set_config(POL_UNUSED, 16'd1);
    run_list(16'd7, '{16'd3, 16'd9});
  endtask

  // Fill the store past capacity so a request gets dropped.
  task automatic test_overflow();
    set_config(dhrs_pkg::POL_SCAN, 16'hFFFF);
    send_cmd(dhrs_pkg::OP_SET_HEAD, 16'h8000);
    repeat (NREQ + 2) send_cmd(dhrs_pkg::OP_ADD, rnd_cyl());
    send_cmd(dhrs_pkg::OP_RUN, 16'h0);
    send_cmd(dhrs_pkg::OP_RUN, 16'h0);
  endtask

  // Random configurations and well-formed command sequences with some noise.
  task automatic test_random();
    int phase, nreq, k;
    logic [CYW-1:0] endc, h, base;
    phase = 0;
    while (items_sent < 220) begin
      case ($urandom_range(3))
        0: endc = 16'd1;
        1: endc = 16'hFFFF;
        default: endc = rnd_cyl();
      endcase
      no_idle = (phase == 2);
      set_config(2'($urandom_range(3)), endc);
      repeat (4) begin
        base = $urandom_range(1) ? rnd_cyl() : rnd_upto(endc);
        h = ($urandom_range(3) == 0) ? rnd_cyl() : base;
        send_cmd(dhrs_pkg::OP_SET_HEAD, h);
        nreq = ($urandom_range(9) == 0) ? $urandom_range(NREQ + 2) : $urandom_range(8);
        for (k = 0; k < nreq; k++) begin
          if ($urandom_range(9) == 0) send_cmd(OP_UNUSED, rnd_cyl());
          if ($urandom_range(4) == 0) send_cmd(dhrs_pkg::OP_ADD, h);
          else send_cmd(dhrs_pkg::OP_ADD, $urandom_range(1) ? rnd_cyl() : rnd_upto(endc));
        end
        send_cmd(dhrs_pkg::OP_RUN, rnd_cyl());
      end
      phase++;
    end
  endtask

  initial begin
    policy = dhrs_pkg::POL_FCFS;
    end_cyl = 16'd199;
    head_pos = '0;
    req_count = 0;
    dropped = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_policies();
    test_overflow();
    test_random();
    start <= 1'b0;
    @(posedge clk);
    while (path_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d commands and %0d runs, checked %0d path points.",
             items_sent, runs_sent, paths_seen);
    $display("All policies, both sweep directions, store overflow and register extremes.");
    if (error_count == 0) begin
      $display("disk_head_request_scheduler regression: pass");
    end else begin
      $display("disk_head_request_scheduler regression: fail");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #40_000_000;
    $display("Timeout with %0d results still expected.", path_queue.size());
    $display("disk_head_request_scheduler regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/dhrs_pkg.sv
src/dhrs_ram.sv
src/dhrs_cmp.sv
src/disk_head_request_scheduler.sv
src/dhrs_checker.sv
test/tb.sv
